// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WRI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define WRI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/wri_pkg.sv =====
// ----------------------------------------------------------------------------
// wri_pkg
// Widths, constants and control structs for the Wilder RSI block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wri_pkg;

  localparam int PRICE_BITS_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int AVG_W       = 64;
  localparam int PERIOD_W    = 16;
  localparam int LEVEL_W     = 15;
  localparam int STAMP_W     = 48;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int NORM_BITS  = 48;
  localparam int RSI_NUM_W  = NORM_BITS + LEVEL_W;
  localparam int RSI_DEN_W  = NORM_BITS + 1;
  localparam int RDIV_CNT_W = $clog2(LEVEL_W);

  localparam int PDIV_STEP  = 4;
  localparam int PDIV_ITER  = AVG_W / PDIV_STEP;
  localparam int PDIV_CNT_W = $clog2(PDIV_ITER);

  localparam logic [LEVEL_W-1:0] RSI_FULL = 15'd25600;
  localparam logic [LEVEL_W-1:0] RSI_HALF = 15'd12800;
  localparam logic [LEVEL_W-1:0] RSI_ZERO = 15'd0;

  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 16'd14;
  localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 15'd17920;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic div_start;
    logic div_lane;
    logic div_smooth;
    logic div_write;
    logic norm_load;
    logic norm_shift;
    logic mul;
    logic rdiv_start;
    logic rdiv_write;
    logic special_write;
    logic out_load;
  } wri_cmd_t;

  typedef struct packed {
    logic have_previous;
    logic warm;
    logic warm_last;
    logic pdiv_busy;
    logic pdiv_done;
    logic rdiv_done;
    logic special;
    logic norm_done;
    logic out_free;
    logic out_full;
  } wri_status_t;

endpackage

// ===== sv/wri_pdiv.sv =====
// ----------------------------------------------------------------------------
// wri_pdiv
// Iterative divider of a 64-bit average by the 16-bit period, radix 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wri_pdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wri_pkg::AVG_W-1:0]     dividend,
  input  logic [wri_pkg::PERIOD_W-1:0]  divisor,
  output logic                          busy,
  output logic                          done,
  output logic [wri_pkg::AVG_W-1:0]     quotient
);
  import wri_pkg::*;

  logic [AVG_W-1:0]      quo;
  logic [PERIOD_W-1:0]   rem;
  logic [PERIOD_W-1:0]   dsr;
  logic [PDIV_CNT_W-1:0] cnt;
  logic [AVG_W-1:0]      step_quo;
  logic [PERIOD_W-1:0]   step_rem;
  logic [PERIOD_W:0]     trial;

  always_comb begin
    step_rem = rem;
    step_quo = quo;
    trial    = '0;
    for (int k = 0; k < PDIV_STEP; k++) begin
      trial    = {step_rem, step_quo[AVG_W-1]};
      step_quo = {step_quo[AVG_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        step_rem    = PERIOD_W'(trial - {1'b0, dsr});
        step_quo[0] = 1'b1;
      end else begin
        step_rem = trial[PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == PDIV_CNT_W'(PDIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= step_quo;
      rem <= step_rem;
    end
  end

  assign quotient = quo;

endmodule

// ===== sv/wri_rdiv.sv =====
// ----------------------------------------------------------------------------
// wri_rdiv
// Restoring divider for the RSI ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wri_rdiv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wri_pkg::RSI_NUM_W-1:0] num,
  input  logic [wri_pkg::RSI_DEN_W-1:0] den,
  output logic                          done,
  output logic [wri_pkg::LEVEL_W-1:0]   quo
);
  import wri_pkg::*;

  logic                  busy;
  logic [RDIV_CNT_W-1:0] cnt;
  logic [RSI_NUM_W-1:0]  rest;
  logic [RSI_NUM_W-1:0]  dsh;
  logic                  fits;

  // quotient is known to stay below 2^LEVEL_W, so the top shift suffices
  assign fits = (rest >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == RDIV_CNT_W'(LEVEL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rest <= num;
      dsh  <= RSI_NUM_W'(den) << (LEVEL_W - 1);
      quo  <= '0;
    end else if (busy) begin
      if (fits) begin
        rest <= rest - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[LEVEL_W-2:0], fits};
    end
  end

endmodule

// ===== sv/wri_datapath.sv =====
// ----------------------------------------------------------------------------
// wri_datapath
// Configuration, price history, averages, dividers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wri_datapath #(
  parameter int PRICE_BITS    = wri_pkg::PRICE_BITS_DEF,
  parameter int FRACTION_BITS = wri_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wri_pkg::wri_cmd_t               cmd,
  output wri_pkg::wri_status_t            sts,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wri_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wri_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [PRICE_BITS-1:0]           price,
  input  logic [wri_pkg::STAMP_W-1:0]     stamp,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [wri_pkg::LEVEL_W-1:0]     rsi_level,
  output logic [wri_pkg::LEVEL_W-1:0]     threshold_out,
  output logic [wri_pkg::STAMP_W-1:0]     stamp_out
);
  import wri_pkg::*;

  localparam int FX_W = PRICE_BITS + FRACTION_BITS;

  logic [PERIOD_W-1:0]   period;
  logic [LEVEL_W-1:0]    threshold;
  logic [PERIOD_W-1:0]   div_val;

  logic                  have_previous;
  logic [PRICE_BITS-1:0] last_price;
  logic [PERIOD_W-1:0]   warm_count;
  logic [AVG_W-1:0]      up_average;
  logic [AVG_W-1:0]      down_average;
  logic [AVG_W-1:0]      up_step;
  logic [AVG_W-1:0]      down_step;
  logic [STAMP_W-1:0]    stamp_hold;

  logic                  rise;
  logic [PRICE_BITS-1:0] diff;
  logic [FX_W-1:0]       fx_wide;
  logic [AVG_W-1:0]      change_fx;

  logic [AVG_W:0]        up_sum;
  logic [AVG_W:0]        down_sum;

  logic [AVG_W-1:0]      lane_avg;
  logic [AVG_W-1:0]      lane_chg;
  logic                  lane_ge;
  logic [AVG_W-1:0]      lane_absd;
  logic [AVG_W-1:0]      div_dividend;
  logic                  div_dir;
  logic [AVG_W-1:0]      div_quo;
  logic [AVG_W-1:0]      lane_new;
  logic                  pdiv_busy;
  logic                  pdiv_done;

  logic [AVG_W-1:0]      work_up;
  logic [AVG_W-1:0]      work_dn;
  logic [RSI_NUM_W-1:0]  rsi_num;
  logic [RSI_DEN_W-1:0]  rsi_den;
  logic                  rdiv_done;
  logic [LEVEL_W-1:0]    rdiv_quo;
  logic [LEVEL_W-1:0]    rsi_val;
  logic [LEVEL_W-1:0]    special_val;
  logic                  up_zero;
  logic                  down_zero;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period    <= PERIOD_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PERIOD:    period    <= cfg_data;
        CFG_THRESHOLD: threshold <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign div_val = (period == '0) ? PERIOD_W'(1) : period;

  // price change in fixed point
  assign rise    = (price > last_price);
  assign diff    = rise ? (price - last_price) : (last_price - price);
  assign fx_wide = {diff, {FRACTION_BITS{1'b0}}};

  generate
    if (FX_W > AVG_W) begin : g_fx_sat
      assign change_fx = (|fx_wide[FX_W-1:AVG_W]) ? '1 : fx_wide[AVG_W-1:0];
    end else begin : g_fx_ext
      assign change_fx = AVG_W'(fx_wide);
    end
  endgenerate

  assign up_sum   = {1'b0, up_average} + {1'b0, up_step};
  assign down_sum = {1'b0, down_average} + {1'b0, down_step};

  // divider operand and write-back
  assign lane_avg     = cmd.div_lane ? down_average : up_average;
  assign lane_chg     = cmd.div_lane ? down_step : up_step;
  assign lane_ge      = (lane_chg >= lane_avg);
  assign lane_absd    = lane_ge ? (lane_chg - lane_avg) : (lane_avg - lane_chg);
  assign div_dividend = cmd.div_smooth ? lane_absd : lane_avg;
  assign lane_new     = !cmd.div_smooth ? div_quo :
                        (div_dir ? (lane_avg + div_quo) : (lane_avg - div_quo));

  wri_pdiv u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_val),
    .busy     (pdiv_busy),
    .done     (pdiv_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      last_price    <= '0;
      warm_count    <= '0;
      up_average    <= '0;
      down_average  <= '0;
    end else begin
      if (cmd.capture) begin
        have_previous <= 1'b1;
        last_price    <= price;
      end
      if (cmd.accumulate) begin
        up_average   <= up_sum[AVG_W] ? '1 : up_sum[AVG_W-1:0];
        down_average <= down_sum[AVG_W] ? '1 : down_sum[AVG_W-1:0];
        warm_count   <= warm_count + 1'b1;
      end
      if (cmd.div_write) begin
        if (cmd.div_lane) begin
          down_average <= lane_new;
        end else begin
          up_average <= lane_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      up_step    <= rise ? change_fx : '0;
      down_step  <= rise ? '0 : change_fx;
      stamp_hold <= stamp;
    end
    if (cmd.div_start) begin
      div_dir <= lane_ge;
    end
  end

  // RSI
  assign up_zero     = (up_average == '0);
  assign down_zero   = (down_average == '0);
  assign special_val = (up_zero && down_zero) ? RSI_HALF :
                       (down_zero ? RSI_FULL : RSI_ZERO);

  always_ff @(posedge clk) begin
    if (cmd.norm_load) begin
      work_up <= up_average;
      work_dn <= down_average;
    end else if (cmd.norm_shift) begin
      work_up <= work_up >> 1;
      work_dn <= work_dn >> 1;
    end
    if (cmd.mul) begin
      rsi_num <= RSI_NUM_W'(work_up[NORM_BITS-1:0]) * RSI_NUM_W'(RSI_FULL);
      rsi_den <= {1'b0, work_up[NORM_BITS-1:0]} + {1'b0, work_dn[NORM_BITS-1:0]};
    end
    if (cmd.special_write) begin
      rsi_val <= special_val;
    end else if (cmd.rdiv_write) begin
      rsi_val <= rdiv_quo;
    end
  end

  wri_rdiv u_rdiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.rdiv_start),
    .num   (rsi_num),
    .den   (rsi_den),
    .done  (rdiv_done),
    .quo   (rdiv_quo)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsi_level     <= rsi_val;
      threshold_out <= threshold;
      stamp_out     <= stamp_hold;
    end
  end

  // status
  assign sts.have_previous = have_previous;
  assign sts.warm          = (warm_count < div_val);
  assign sts.warm_last     = ({1'b0, warm_count} + 1'b1) == {1'b0, div_val};
  assign sts.pdiv_busy     = pdiv_busy;
  assign sts.pdiv_done     = pdiv_done;
  assign sts.rdiv_done     = rdiv_done;
  assign sts.special       = up_zero || down_zero;
  assign sts.norm_done     = ~|((work_up | work_dn) >> NORM_BITS);
  assign sts.out_free      = !result_valid || !result_stall;
  assign sts.out_full      = result_valid;

  `WRI_ASSERT_IMP(a_rsi_range, rdiv_done, rdiv_quo <= RSI_FULL)
  `WRI_ASSERT_IMP(a_accum_after_first, cmd.accumulate, have_previous)

endmodule

// ===== sv/wri_ctrl.sv =====
// ----------------------------------------------------------------------------
// wri_ctrl
// Sequencer: warm-up, seeding, smoothing, RSI ratio and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wri_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  wri_pkg::wri_status_t sts,
  output wri_pkg::wri_cmd_t    cmd
);
  import wri_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ACCUM     = 4'd1;
  localparam logic [3:0] S_UP_GO     = 4'd2;
  localparam logic [3:0] S_UP_WAIT   = 4'd3;
  localparam logic [3:0] S_DN_GO     = 4'd4;
  localparam logic [3:0] S_DN_WAIT   = 4'd5;
  localparam logic [3:0] S_NORM_LOAD = 4'd6;
  localparam logic [3:0] S_NORM      = 4'd7;
  localparam logic [3:0] S_MUL       = 4'd8;
  localparam logic [3:0] S_RDIV_GO   = 4'd9;
  localparam logic [3:0] S_RDIV_WAIT = 4'd10;
  localparam logic [3:0] S_OUT       = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       smooth;
  logic       smooth_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    smooth_next = smooth;
    cmd         = '0;
    cmd.div_smooth = smooth;
    cmd.div_lane   = (state == S_DN_GO) || (state == S_DN_WAIT);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          if (sts.have_previous) begin
            if (sts.warm) begin
              smooth_next = 1'b0;
              state_next  = S_ACCUM;
            end else begin
              smooth_next = 1'b1;
              state_next  = S_UP_GO;
            end
          end
        end
      end
      S_ACCUM: begin
        cmd.accumulate = 1'b1;
        state_next     = sts.warm_last ? S_UP_GO : S_IDLE;
      end
      S_UP_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_UP_WAIT;
      end
      S_UP_WAIT: begin
        if (sts.pdiv_done) begin
          cmd.div_write = 1'b1;
          state_next    = S_DN_GO;
        end
      end
      S_DN_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DN_WAIT;
      end
      S_DN_WAIT: begin
        if (sts.pdiv_done) begin
          cmd.div_write = 1'b1;
          state_next    = smooth ? S_NORM_LOAD : S_IDLE;
        end
      end
      S_NORM_LOAD: begin
        cmd.norm_load = 1'b1;
        if (sts.special) begin
          cmd.special_write = 1'b1;
          state_next        = S_OUT;
        end else begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          state_next = S_MUL;
        end else begin
          cmd.norm_shift = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RDIV_GO;
      end
      S_RDIV_GO: begin
        cmd.rdiv_start = 1'b1;
        state_next     = S_RDIV_WAIT;
      end
      S_RDIV_WAIT: begin
        if (sts.rdiv_done) begin
          cmd.rdiv_write = 1'b1;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      smooth <= 1'b0;
    end else begin
      state  <= state_next;
      smooth <= smooth_next;
    end
  end

  `WRI_ASSERT_IMP(a_div_start_idle, cmd.div_start, !sts.pdiv_busy)
  `WRI_ASSERT_NXT(a_out_loaded, (state == S_OUT) && sts.out_free, sts.out_full)

endmodule

// ===== sv/wilder_rsi_indicator.sv =====
// ----------------------------------------------------------------------------
// wilder_rsi_indicator
// Wilder-smoothed relative strength index over a stream of closing prices.
// ----------------------------------------------------------------------------
// One request per candle (price, stamp). The first price after reset is only
// stored; a warm-up change is accumulated; the change that completes warm-up
// is accumulated too and then seeds both averages. Each later change gives
// one result, with extra steps when an average is 2^48 or more and both must
// be scaled down one bit per cycle, and with no RSI division when an average
// is zero. The work is done by the shared radix-16 period divider, run once
// per average, and the bit-serial RSI divider. A finished result waits in an
// output register; the next request is taken as soon as it is loaded.
// Configuration writes are always ready.
`timescale 1ns / 1ps

module wilder_rsi_indicator #(
  parameter int PRICE_BITS    = wri_pkg::PRICE_BITS_DEF,
  parameter int FRACTION_BITS = wri_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wri_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wri_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [PRICE_BITS-1:0]           price,
  input  logic [wri_pkg::STAMP_W-1:0]     stamp,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [wri_pkg::LEVEL_W-1:0]     rsi_level,
  output logic [wri_pkg::LEVEL_W-1:0]     threshold_out,
  output logic [wri_pkg::STAMP_W-1:0]     stamp_out
);
  import wri_pkg::*;

  wri_cmd_t    cmd;
  wri_status_t sts;

  wri_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  wri_datapath #(
    .PRICE_BITS    (PRICE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .price         (price),
    .stamp         (stamp),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .rsi_level     (rsi_level),
    .threshold_out (threshold_out),
    .stamp_out     (stamp_out)
  );

endmodule
